[rtl/trpd_pkg.sv]
// Shared types and constants for the TGA run-length pixel decoder.
// Used by trpd_ctrl, trpd_datapath and the top level; depends on nothing.

package trpd_pkg;

  localparam int BYTE_W     = 8;
  localparam int BPP_W      = 3;
  localparam int COUNT_W    = 25;
  localparam int PIXEL_W    = 32;
  localparam int REMAIN_W   = 7;
  localparam int COPIES_W   = 8;
  localparam int LANE_W     = 2;
  localparam int PAIR_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COUNT_W;

  localparam int unsigned MAX_PIXELS_DEFAULT = 32'd16777216;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT     = 1'b1;

  localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd4;
  localparam logic [BPP_W-1:0]   BPP_MAX     = 3'd4;
  localparam logic [BPP_W-1:0]   BPP_MIN     = 3'd1;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 25'd1;

  // Pair counts carried in a result.
  localparam logic [PAIR_W-1:0] PAIR_NONE = 2'd0;
  localparam logic [PAIR_W-1:0] PAIR_ONE  = 2'd1;
  localparam logic [PAIR_W-1:0] PAIR_TWO  = 2'd2;

  // A header byte with its top bit set opens a run packet.
  localparam int RUN_FLAG_BIT = 7;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_RAW,
    PH_RUN
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HOLD,
    S_RUN
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic process;
    logic use_held;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic run_cont;
  } sts_t;

endpackage

[rtl/trpd_ctrl.sv]
// Sequencing state machine of the TGA run-length pixel decoder.
// Depends on trpd_pkg for the state, command and status types.

module trpd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  trpd_pkg::sts_t sts,
  output trpd_pkg::cmd_t cmd
);
  import trpd_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.slot_free) begin
            state_next = sts.run_cont ? S_RUN : S_IDLE;
          end else begin
            state_next = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (sts.slot_free) begin
          state_next = sts.run_cont ? S_RUN : S_IDLE;
        end
      end
      S_RUN: begin
        if (sts.slot_free && !sts.run_cont) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state != S_IDLE);
    cmd.capture  = (state == S_IDLE) && in_valid && !sts.slot_free;
    cmd.process  = ((state == S_IDLE) && in_valid && sts.slot_free) ||
                   ((state == S_HOLD) && sts.slot_free);
    cmd.use_held = (state == S_HOLD);
    cmd.step     = (state == S_RUN) && sts.slot_free;
  end

  // A byte is only worked on, or a run continued, when the output register can take a result.
  a_cmd_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.process || cmd.step) |-> sts.slot_free)
    else $error("work issued while the output register is blocked");

  // A captured byte must be held until the output register frees up.
  a_capture_holds: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == S_HOLD))
    else $error("captured byte not held");

endmodule

[rtl/trpd_datapath.sv]
// Datapath of the TGA run-length pixel decoder: configuration, packet state,
// pixel assembly, run emission and the output register. Depends on trpd_pkg.

module trpd_datapath #(
  parameter int unsigned MAX_PIXELS = trpd_pkg::MAX_PIXELS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [trpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [trpd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [trpd_pkg::BYTE_W-1:0]          stream_byte,
  input  trpd_pkg::cmd_t                       cmd,
  output trpd_pkg::sts_t                       sts,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [trpd_pkg::PIXEL_W-1:0]         pixel_first,
  output logic [trpd_pkg::PIXEL_W-1:0]         pixel_second,
  output logic [trpd_pkg::PAIR_W-1:0]          pair_count,
  output logic                                 last_of_run,
  output logic                                 image_done,
  output logic                                 status
);
  import trpd_pkg::*;

  localparam int unsigned CountMax = (32'd1 << COUNT_W) - 32'd1;
  localparam int unsigned LimitCap = (MAX_PIXELS > CountMax) ? CountMax : MAX_PIXELS;

  // Configuration and packet state.
  logic [BPP_W-1:0]    bytes_per_pixel;
  logic [COUNT_W-1:0]  pixel_count;
  phase_t              phase, phase_next;
  logic [REMAIN_W-1:0] remaining, remaining_next;
  logic [LANE_W-1:0]   byte_in_pixel, byte_in_pixel_next;
  logic [PIXEL_W-1:0]  assembly, assembly_next;
  logic [COUNT_W-1:0]  pixels_done, pixels_done_next;
  logic                error_flag, error_next;
  logic [COPIES_W-1:0] copies_left, copies_left_next;
  logic [PIXEL_W-1:0]  run_pix, run_pix_next;
  logic [BYTE_W-1:0]   held_byte;

  // Result being formed this cycle.
  logic                produce;
  logic [PIXEL_W-1:0]  res_first, res_second;
  logic [PAIR_W-1:0]   res_count;
  logic                res_last, res_done, res_status;

  logic [BPP_W-1:0]    bpp_eff;
  logic [COUNT_W-1:0]  limit;
  logic [BYTE_W-1:0]   byte_sel;
  logic [PIXEL_W-1:0]  assembly_merged;
  logic                pixel_complete;
  logic                do_step;
  logic                step_is_raw;
  logic [PIXEL_W-1:0]  step_pix;
  logic [COPIES_W-1:0] step_copies;
  logic [COUNT_W-1:0]  pd_one, pd_two, pd_new;
  logic                end_pkt;

  always_comb begin
    if (bytes_per_pixel == '0) begin
      bpp_eff = BPP_MIN;
    end else if (bytes_per_pixel > BPP_MAX) begin
      bpp_eff = BPP_MAX;
    end else begin
      bpp_eff = bytes_per_pixel;
    end
    limit = (pixel_count > COUNT_W'(LimitCap)) ? COUNT_W'(LimitCap) : pixel_count;
  end

  assign byte_sel        = cmd.use_held ? held_byte : stream_byte;
  assign assembly_merged = assembly |
                           (PIXEL_W'(byte_sel) << {byte_in_pixel, 3'b000});
  assign pixel_complete  = (({1'b0, byte_in_pixel} + 3'd1) >= bpp_eff);
  assign pd_one          = pixels_done + COUNT_W'(1);
  assign pd_two          = pixels_done + COUNT_W'(2);

  always_comb begin
    phase_next         = phase;
    remaining_next     = remaining;
    byte_in_pixel_next = byte_in_pixel;
    assembly_next      = assembly;
    pixels_done_next   = pixels_done;
    error_next         = error_flag;
    copies_left_next   = copies_left;
    run_pix_next       = run_pix;
    produce            = 1'b0;
    res_first          = '0;
    res_second         = '0;
    res_count          = PAIR_NONE;
    res_last           = 1'b1;
    res_done           = 1'b0;
    res_status         = 1'b0;
    do_step            = 1'b0;
    step_is_raw        = 1'b0;
    step_pix           = run_pix;
    step_copies        = copies_left;
    pd_new             = pixels_done;
    end_pkt            = 1'b0;
    sts.slot_free      = !out_valid || !out_stall;
    sts.run_cont       = 1'b0;

    if (cmd.process) begin
      priority if (error_flag) begin
        produce    = 1'b1;
        res_status = 1'b1;
      end else if (phase == PH_HEADER) begin
        phase_next         = byte_sel[RUN_FLAG_BIT] ? PH_RUN : PH_RAW;
        remaining_next     = byte_sel[REMAIN_W-1:0];
        byte_in_pixel_next = '0;
        assembly_next      = '0;
      end else if (!pixel_complete) begin
        byte_in_pixel_next = byte_in_pixel + LANE_W'(1);
        assembly_next      = assembly_merged;
      end else begin
        byte_in_pixel_next = '0;
        assembly_next      = '0;
        do_step            = 1'b1;
        step_pix           = assembly_merged;
        step_is_raw        = (phase == PH_RAW);
        step_copies        = step_is_raw ? COPIES_W'(1) :
                             ({1'b0, remaining} + COPIES_W'(1));
      end
    end else if (cmd.step) begin
      do_step = 1'b1;
    end

    // One result: either the last copy, an excess pixel, or a pair.
    if (do_step) begin
      produce = 1'b1;
      priority if (pixels_done >= limit) begin
        error_next = 1'b1;
        res_status = 1'b1;
      end else if (step_copies == COPIES_W'(1)) begin
        res_first = step_pix;
        res_count = PAIR_ONE;
        res_done  = (pd_one == limit);
        pd_new    = pd_one;
        end_pkt   = 1'b1;
      end else if (pd_one >= limit) begin
        // Second copy of the pair overruns the image.
        res_first  = step_pix;
        res_count  = PAIR_ONE;
        res_done   = 1'b1;
        res_status = 1'b1;
        error_next = 1'b1;
        pd_new     = pd_one;
      end else begin
        res_first  = step_pix;
        res_second = step_pix;
        res_count  = PAIR_TWO;
        res_done   = (pd_two == limit);
        pd_new     = pd_two;
        if (step_copies == COPIES_W'(2)) begin
          end_pkt = 1'b1;
        end else begin
          res_last         = 1'b0;
          sts.run_cont     = 1'b1;
          copies_left_next = step_copies - COPIES_W'(2);
          run_pix_next     = step_pix;
        end
      end
      pixels_done_next = pd_new;

      if (end_pkt) begin
        if (step_is_raw && (remaining != '0)) begin
          remaining_next = remaining - REMAIN_W'(1);
        end else begin
          phase_next     = PH_HEADER;
          remaining_next = '0;
          if (pd_new >= limit) begin
            pixels_done_next = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BPP_RESET;
      pixel_count     <= COUNT_RESET;
      phase           <= PH_HEADER;
      remaining       <= '0;
      byte_in_pixel   <= '0;
      assembly        <= '0;
      pixels_done     <= '0;
      error_flag      <= 1'b0;
      copies_left     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[BPP_W-1:0];
          CFG_PIXEL_COUNT:     pixel_count     <= cfg_data[COUNT_W-1:0];
          default:             pixel_count     <= pixel_count;
        endcase
      end
      phase         <= phase_next;
      remaining     <= remaining_next;
      byte_in_pixel <= byte_in_pixel_next;
      assembly      <= assembly_next;
      pixels_done   <= pixels_done_next;
      error_flag    <= error_next;
      copies_left   <= copies_left_next;
      out_valid     <= produce || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      held_byte <= stream_byte;
    end
    run_pix <= run_pix_next;
    if (produce) begin
      pixel_first  <= res_first;
      pixel_second <= res_second;
      pair_count   <= res_count;
      last_of_run  <= res_last;
      image_done   <= res_done;
      status       <= res_status;
    end
  end

  // Once the sticky error is up, every result in the output register carries it.
  a_sticky_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_flag) |-> status)
    else $error("result without error status after overrun");

  // Pairs only come from runs, so both halves are the same pixel.
  a_pair_same: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (pair_count == PAIR_TWO)) |-> (pixel_first == pixel_second))
    else $error("pair halves differ");

  // An empty result is always an error-only, closing result.
  a_empty_is_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (pair_count == PAIR_NONE)) |->
      (status && last_of_run && (pixel_first == '0)))
    else $error("malformed error-only result");

endmodule

[rtl/tga_rle_pixel_decoder_unit.sv]
// Top level of the TGA run-length pixel decoder.
// Instantiates trpd_ctrl and trpd_datapath; depends on trpd_pkg.
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid / in_stall  stream_byte
//   output    out        out_valid/out_stall  pixel_first, pixel_second, pair_count,
//                                             last_of_run, image_done, status
//   config    in         cfg_write            cfg_index, cfg_data
//
// A header byte, a partial pixel byte, or a byte giving a single result is worked on in its accept cycle.
// A run pixel of N copies produces its first pair in the accept cycle and holds the input
// stalled for the rest, one result per cycle while out_stall is low, pairs bar an odd last copy.
// A byte arriving while the output register is blocked is taken into a one-byte hold stage
// and worked on once that register frees, with the input stalled meanwhile.
// Synchronous active-high reset clears the controller, packet state and error flag, and
// loads the pixel size with four bytes and the pixel count with one.

module tga_rle_pixel_decoder_unit #(
  parameter int unsigned MAX_PIXELS = trpd_pkg::MAX_PIXELS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [trpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trpd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [trpd_pkg::BYTE_W-1:0]     stream_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [trpd_pkg::PIXEL_W-1:0]    pixel_first,
  output logic [trpd_pkg::PIXEL_W-1:0]    pixel_second,
  output logic [trpd_pkg::PAIR_W-1:0]     pair_count,
  output logic                            last_of_run,
  output logic                            image_done,
  output logic                            status
);
  import trpd_pkg::*;

  // Commands from the sequencer and status back from the datapath.
  cmd_t cmd;
  sts_t sts;

  // The sequencer decides when a transaction's byte is worked on: straight away,
  // after a wait in the hold stage, or as a run that goes on with the input stalled.
  trpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the configuration, the packet and image counters, the
  // sticky error and the output register that parts the two channels.
  trpd_datapath #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .stream_byte  (stream_byte),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_first  (pixel_first),
    .pixel_second (pixel_second),
    .pair_count   (pair_count),
    .last_of_run  (last_of_run),
    .image_done   (image_done),
    .status       (status)
  );

endmodule

[test/tb_top.sv]
// Self-checking testbench for tga_rle_pixel_decoder_unit, the TGA run-length pixel decoder.
// Holds its own decoder predictor and drives a directed table, random images and an
// overrun at the end. Depends on trpd_pkg and the RTL of the decoder only.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import trpd_pkg::*;

  // One result transaction of the output channel, field by field.
  typedef struct packed {
    logic [PIXEL_W-1:0] px_first;
    logic [PIXEL_W-1:0] px_second;
    logic [PAIR_W-1:0]  pairs;
    logic               run_end;
    logic               img_done;
    logic               err;
  } pix_result_t;

  // A row of the directed table either writes a register or offers one byte. A typed row
  // carries the single result that its byte must give, worked out by hand.
  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_TYPED,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [BYTE_W-1:0]     value;
    pix_result_t           want;
  } stim_row_t;

  localparam pix_result_t NO_PIX = '0;
  localparam int          RANDOM_ITEMS = 240;
  localparam int          HOLD_CYCLES = 300;

  // The directed part opens with the state left by reset (four-byte pixels, one-pixel
  // images), then walks through the longest run packet, a raw packet that closes an
  // image, pixel sizes of zero and seven (taken as one and four), the all-ones pixel,
  // and a write of the pixel size with junk in the upper data bits.
  localparam stim_row_t DIRECTED [35] = '{
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'h00, NO_PIX},
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'h11, NO_PIX},
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'h22, NO_PIX},
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'h33, NO_PIX},
    '{ROW_TYPED, CFG_BYTES_PER_PIXEL, '0, 8'h44,
      '{32'h44332211, 32'h0, PAIR_ONE, 1'b1, 1'b1, 1'b0}},
    '{ROW_CFG,   CFG_BYTES_PER_PIXEL, 25'd1, 8'h00, NO_PIX},
    '{ROW_CFG,   CFG_PIXEL_COUNT,     25'd130, 8'h00, NO_PIX},
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'hFF, NO_PIX},
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'h00, NO_PIX},
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'h01, NO_PIX},
    '{ROW_TYPED, CFG_BYTES_PER_PIXEL, '0, 8'hFF,
      '{32'h000000FF, 32'h0, PAIR_ONE, 1'b1, 1'b0, 1'b0}},
    '{ROW_TYPED, CFG_BYTES_PER_PIXEL, '0, 8'h80,
      '{32'h00000080, 32'h0, PAIR_ONE, 1'b1, 1'b1, 1'b0}},
    '{ROW_CFG,   CFG_BYTES_PER_PIXEL, 25'd0, 8'h00, NO_PIX},
    '{ROW_CFG,   CFG_PIXEL_COUNT,     25'd4, 8'h00, NO_PIX},
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'h81, NO_PIX},
    '{ROW_TYPED, CFG_BYTES_PER_PIXEL, '0, 8'hAB,
      '{32'h000000AB, 32'h000000AB, PAIR_TWO, 1'b1, 1'b0, 1'b0}},
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'h01, NO_PIX},
    '{ROW_TYPED, CFG_BYTES_PER_PIXEL, '0, 8'h00,
      '{32'h00000000, 32'h0, PAIR_ONE, 1'b1, 1'b0, 1'b0}},
    '{ROW_TYPED, CFG_BYTES_PER_PIXEL, '0, 8'h5A,
      '{32'h0000005A, 32'h0, PAIR_ONE, 1'b1, 1'b1, 1'b0}},
    '{ROW_CFG,   CFG_BYTES_PER_PIXEL, 25'd7, 8'h00, NO_PIX},
    '{ROW_CFG,   CFG_PIXEL_COUNT,     25'd3, 8'h00, NO_PIX},
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'h82, NO_PIX},
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'hFF, NO_PIX},
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'hFF, NO_PIX},
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'hFF, NO_PIX},
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'hFF, NO_PIX},
    '{ROW_CFG,   CFG_BYTES_PER_PIXEL, 25'h1FFFFFB, 8'h00, NO_PIX},
    '{ROW_CFG,   CFG_PIXEL_COUNT,     25'd2, 8'h00, NO_PIX},
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'h01, NO_PIX},
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'h01, NO_PIX},
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'h02, NO_PIX},
    '{ROW_TYPED, CFG_BYTES_PER_PIXEL, '0, 8'h03,
      '{32'h00030201, 32'h0, PAIR_ONE, 1'b1, 1'b0, 1'b0}},
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'hFE, NO_PIX},
    '{ROW_BYTE,  CFG_BYTES_PER_PIXEL, '0, 8'hFD, NO_PIX},
    '{ROW_TYPED, CFG_BYTES_PER_PIXEL, '0, 8'hFC,
      '{32'h00FCFDFE, 32'h0, PAIR_ONE, 1'b1, 1'b1, 1'b0}}
  };

  // Every input of the block is given a known value from time zero.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     stream_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PIXEL_W-1:0]    pixel_first;
  logic [PIXEL_W-1:0]    pixel_second;
  logic [PAIR_W-1:0]     pair_count;
  logic                  last_of_run;
  logic                  image_done;
  logic                  status;

  // Predictor state: the decoder as the testbench believes it to be.
  logic [BPP_W-1:0]    cfg_bpp = BPP_RESET;
  logic [COUNT_W-1:0]  cfg_count = COUNT_RESET;
  phase_t              dec_phase = PH_HEADER;
  logic [7:0]          dec_left = '0;
  logic [LANE_W-1:0]   dec_lane = '0;
  logic [PIXEL_W-1:0]  dec_word = '0;
  int unsigned         dec_done_cnt = 0;
  logic                dec_err = 1'b0;

  pix_result_t step_out[$];     // results of the byte just decoded
  pix_result_t due_pixels[$];   // results still owed by the block, oldest first

  // Shared between the stimulus, the receiver and the monitor.
  int          bytes_taken = 0;
  int          mismatches = 0;
  bit          row_typed = 1'b0;
  pix_result_t row_want = '0;
  bit          no_idle = 1'b0;
  int          hold_asks = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  tga_rle_pixel_decoder_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .stream_byte  (stream_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_first  (pixel_first),
    .pixel_second (pixel_second),
    .pair_count   (pair_count),
    .last_of_run  (last_of_run),
    .image_done   (image_done),
    .status       (status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // A pixel size of zero is taken as one byte and anything above four as four.
  function automatic int unsigned eff_bpp();
    if (cfg_bpp == 0) return 1;
    if (cfg_bpp > 4) return 4;
    return 32'(cfg_bpp);
  endfunction

  // The image can never be larger than the block's own ceiling.
  function automatic int unsigned eff_limit();
    return (32'(cfg_count) > MAX_PIXELS_DEFAULT) ? MAX_PIXELS_DEFAULT : 32'(cfg_count);
  endfunction

  // A packet has ended; when the image is complete the pixel tally starts again.
  function automatic void close_packet();
    dec_phase = PH_HEADER;
    dec_left = '0;
    if (dec_done_cnt >= eff_limit()) dec_done_cnt = 0;
  endfunction

  // Sends out a number of copies of one pixel, two to a result. A copy beyond the image
  // size raises the error flag and drops the rest; the last result then carries the error.
  function automatic void emit_copies(input logic [PIXEL_W-1:0] pix, input int unsigned copies);
    int unsigned       pend;
    int unsigned       i;
    logic [PIXEL_W-1:0] held;
    logic              done;
    pend = 0;
    held = '0;
    done = 1'b0;
    for (i = 0; i < copies; i++) begin
      if (dec_done_cnt >= eff_limit()) begin
        dec_err = 1'b1;
        break;
      end
      if (pend == 0) held = pix;
      pend++;
      dec_done_cnt++;
      if (dec_done_cnt == eff_limit()) done = 1'b1;
      if (pend == 2) begin
        step_out.push_back('{held, pix, PAIR_TWO, 1'b0, done, 1'b0});
        pend = 0;
        done = 1'b0;
      end
    end
    if (pend != 0 || dec_err)
      step_out.push_back('{(pend != 0) ? held : '0, '0, PAIR_W'(pend), 1'b0, done, dec_err});
    if (step_out.size() > 0) step_out[step_out.size() - 1].run_end = 1'b1;
  endfunction

  // Works out every result that one accepted byte causes, into step_out.
  function automatic void decode_stream_byte(input logic [BYTE_W-1:0] b);
    logic [PIXEL_W-1:0] pix;
    step_out.delete();
    if (dec_err) begin
      // Once an image has overrun, every byte just reports the error again.
      step_out.push_back('{'0, '0, PAIR_NONE, 1'b1, 1'b0, 1'b1});
    end else if (dec_phase == PH_HEADER) begin
      if (b[RUN_FLAG_BIT]) begin
        dec_phase = PH_RUN;
        dec_left = b - 8'd128;
      end else begin
        dec_phase = PH_RAW;
        dec_left = b;
      end
      dec_lane = '0;
      dec_word = '0;
    end else begin
      dec_word = dec_word | (PIXEL_W'(b) << (8 * dec_lane));
      if (int'(dec_lane) + 1 < eff_bpp()) begin
        dec_lane = dec_lane + 1'b1;
      end else begin
        pix = dec_word;
        dec_lane = '0;
        dec_word = '0;
        if (dec_phase == PH_RAW) begin
          emit_copies(pix, 1);
          if (!dec_err) begin
            if (dec_left == 0) close_packet();
            else dec_left = dec_left - 1'b1;
          end
        end else begin
          emit_copies(pix, int'(dec_left) + 1);
          if (!dec_err) close_packet();
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Monitor: both channels are sampled at the rising edge. A byte transaction is decoded
  // before the result transaction of the same edge is checked, so that a result that
  // follows its byte at once still finds its expectation waiting.
  // ---------------------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input pix_result_t want,
                               input pix_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected first=%h second=%h pairs=%0d last=%0b done=%0b status=%0b",
               want.px_first, want.px_second, want.pairs, want.run_end, want.img_done,
               want.err);
      $display("  actual   first=%h second=%h pairs=%0d last=%0b done=%0b status=%0b",
               got.px_first, got.px_second, got.pairs, got.run_end, got.img_done, got.err);
    end
  endtask

  always @(posedge clk) begin
    pix_result_t got;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        decode_stream_byte(stream_byte);
        if (row_typed) due_pixels.push_back(row_want);
        else foreach (step_out[k]) due_pixels.push_back(step_out[k]);
        bytes_taken++;
      end
      if (out_valid && !out_stall) begin
        got = '{pixel_first, pixel_second, pair_count, last_of_run, image_done, status};
        if (due_pixels.size() == 0) note_mismatch("result transaction with none due", '0, got);
        else if (got !== due_pixels[0]) note_mismatch("result mismatch", due_pixels[0], got);
        if (due_pixels.size() != 0) void'(due_pixels.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Receiver: stalls in about a quarter of the cycles, never while no_idle is set, and
  // holds off for a long stretch when the stimulus asks for it, so that the block fills
  // and has to stall its input.
  // ---------------------------------------------------------------------------------------

  initial begin
    forever begin
      @(negedge clk);
      if (hold_served != hold_asks) begin
        hold_served = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = !no_idle && ($urandom_range(99, 0) < 25);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus. Every task starts and ends at a falling edge, where the inputs change.
  // ---------------------------------------------------------------------------------------

  // Offers one byte, sometimes after a short gap, and waits for its transaction.
  task automatic send_byte(input logic [BYTE_W-1:0] value, input bit typed = 1'b0,
                           input pix_result_t want = '0);
    int mark;
    if (!no_idle && $urandom_range(99, 0) < 20) begin
      in_valid = 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk);
    end
    mark = bytes_taken;
    row_typed = typed;
    row_want = want;
    stream_byte = value;
    in_valid = 1'b1;
    do @(negedge clk); while (bytes_taken == mark);
  endtask

  // Registers change only when the block is idle: every owed result has come back and a
  // trailing header byte, which owes nothing, has had time to pass through.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_valid = 1'b0;
    while (due_pixels.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_index = idx;
    cfg_data = data;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == CFG_BYTES_PER_PIXEL) cfg_bpp = data[BPP_W-1:0];
    else cfg_count = data[COUNT_W-1:0];
  endtask

  // Sends well-formed packets that together carry exactly n pixels, so that the image
  // never overruns. Packets are mostly short; some are the longest a header allows. Long
  // raw packets are kept to one-byte pixels to hold the byte count down.
  task automatic send_pixels(input int unsigned n);
    int unsigned len;
    int unsigned bpp;
    int          r;
    bit          is_run;
    while (n > 0) begin
      bpp = eff_bpp();
      is_run = ($urandom_range(99, 0) < 65);
      r = $urandom_range(99, 0);
      if (r < 10) len = 128;
      else if (r < 20) len = 1;
      else if (r < 30) len = $urandom_range(128, 1);
      else len = $urandom_range(8, 1);
      if (!is_run && bpp > 1 && len > 8) len = $urandom_range(8, 1);
      if (len > n) len = n;
      if (is_run) begin
        send_byte(BYTE_W'(127 + len));
        repeat (bpp) send_byte(BYTE_W'($urandom));
      end else begin
        send_byte(BYTE_W'(len - 1));
        repeat (len * bpp) send_byte(BYTE_W'($urandom));
      end
      n = n - len;
    end
  endtask

  initial begin
    int                    start_taken;
    int                    phase_no;
    int                    variant;
    int                    npix;
    logic [BYTE_W-1:0]     hdr;
    logic [CFG_DATA_W-1:0] bpp_data;
    logic [CFG_DATA_W-1:0] count_val;

    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed table.
    foreach (DIRECTED[i]) begin
      case (DIRECTED[i].kind)
        ROW_CFG: begin
          write_reg(DIRECTED[i].idx, DIRECTED[i].data);
        end
        ROW_TYPED: begin
          send_byte(DIRECTED[i].value, 1'b1, DIRECTED[i].want);
        end
        default: begin
          send_byte(DIRECTED[i].value);
        end
      endcase
    end

    // Random images. Each phase sets both registers while the block is idle and then sends
    // one whole image, so that the block rearms before the next phase. The first random
    // phase runs with no idling on either side; the second starts with the long receiver
    // hold-off; the third changes the registers half way through an image. Further
    // ordinary phases follow until the byte budget is spent.
    start_taken = bytes_taken;
    phase_no = 0;
    while (phase_no < 3 || bytes_taken - start_taken < RANDOM_ITEMS) begin
      if ($urandom_range(1, 0) == 1)
        bpp_data = {22'($urandom), 3'($urandom_range(7, 0))};
      else
        bpp_data = CFG_DATA_W'($urandom_range(7, 0));
      write_reg(CFG_BYTES_PER_PIXEL, bpp_data);
      if (phase_no == 2) begin
        // An oversized count acts as the ceiling, so the image cannot end here; the count
        // is then cut back so that a few more pixels complete it.
        if ($urandom_range(1, 0) == 1) write_reg(CFG_PIXEL_COUNT, 25'h1FFFFFF);
        else write_reg(CFG_PIXEL_COUNT, CFG_DATA_W'(MAX_PIXELS_DEFAULT));
        send_pixels($urandom_range(30, 5));
        write_reg(CFG_BYTES_PER_PIXEL, CFG_DATA_W'($urandom_range(7, 0)));
        write_reg(CFG_PIXEL_COUNT, CFG_DATA_W'(dec_done_cnt + $urandom_range(20, 1)));
        send_pixels(eff_limit() - dec_done_cnt);
      end else begin
        if (phase_no == 1) count_val = CFG_DATA_W'(40);
        else if ($urandom_range(99, 0) < 15) count_val = CFG_DATA_W'($urandom_range(64, 41));
        else count_val = CFG_DATA_W'($urandom_range(40, 1));
        write_reg(CFG_PIXEL_COUNT, count_val);
        no_idle = (phase_no == 0);
        if (phase_no == 1) hold_asks++;
        send_pixels(eff_limit());
        no_idle = 1'b0;
      end
      phase_no++;
    end

    // Overrun, which is sticky until reset and so comes last: either a run that passes the
    // end of the image with an odd pixel left over or with none, an image size of zero, or
    // a raw packet longer than the image. Every byte after that gives the error alone.
    variant = $urandom_range(3, 0);
    write_reg(CFG_BYTES_PER_PIXEL, CFG_DATA_W'($urandom_range(4, 1)));
    case (variant)
      0: begin
        count_val = CFG_DATA_W'(3);
        hdr = 8'h84;
        npix = 1;
      end
      1: begin
        count_val = CFG_DATA_W'(2);
        hdr = 8'h84;
        npix = 1;
      end
      2: begin
        count_val = CFG_DATA_W'(0);
        hdr = 8'h00;
        npix = 1;
      end
      default: begin
        count_val = CFG_DATA_W'(2);
        hdr = 8'h04;
        npix = 3;
      end
    endcase
    write_reg(CFG_PIXEL_COUNT, count_val);
    send_byte(hdr);
    repeat (npix * eff_bpp()) send_byte(BYTE_W'($urandom));
    repeat (20) send_byte(BYTE_W'($urandom));

    // Drain, then allow the block's latency for any stray result to show itself.
    in_valid = 1'b0;
    while (due_pixels.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("** tga_rle_pixel_decoder_unit: PASSED **");
    end else begin
      $display("** tga_rle_pixel_decoder_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run: every byte giving its most results, each
  // of them waiting out the longest stall, and the hold-off on top.
  initial begin
    #5_000_000;
    $display("** tga_rle_pixel_decoder_unit: FAILED **");
    $finish;
  end

endmodule
